// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the rising clock edge, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Same, with the consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rhd_pkg.sv
// ----------------------------------------------------------------------------
// rhd_pkg
// Types and constants shared by the RGBA half downsample block.
// ----------------------------------------------------------------------------
`default_nettype none

package rhd_pkg;

  localparam int MaxWidth    = 2048;
  localparam int MaxHeight   = 2048;
  localparam int RowSlots    = MaxWidth / 2;
  localparam int SlotBits    = $clog2(RowSlots);
  localparam int PosBits     = $clog2(MaxWidth);
  localparam int DimBits     = 12;
  localparam int CfgIdxBits  = 8;
  localparam int NumChan     = 4;
  localparam int ChanBits    = 8;
  // A stored row sum is at most 127, since it only exists when the value is
  // shifted at least once.
  localparam int HalfBits    = ChanBits - 1;
  localparam int RamBits     = NumChan * HalfBits;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgImageWidth  = 8'd0,
    CfgImageHeight = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanBits-1:0] in_alpha;
    logic [ChanBits-1:0] in_blue;
    logic [ChanBits-1:0] in_green;
    logic [ChanBits-1:0] in_red;
  } pixel_in_t;

  typedef struct packed {
    logic                frame_end;
    logic [ChanBits-1:0] out_alpha;
    logic [ChanBits-1:0] out_blue;
    logic [ChanBits-1:0] out_green;
    logic [ChanBits-1:0] out_red;
  } pixel_out_t;

  typedef logic [NumChan-1:0][ChanBits-1:0] chan_vec_t;
  typedef logic [NumChan-1:0][HalfBits-1:0] half_vec_t;

  // Item handed from the accept stage to the merge stage.
  typedef struct packed {
    logic      emit;
    logic      add_upper;
    logic      frame_end;
    chan_vec_t hsum;
  } rhd_item_t;

  // Row buffer access issued at the accept edge.
  typedef struct packed {
    logic                we;
    logic                re;
    logic [SlotBits-1:0] addr;
    half_vec_t           wdata;
  } rhd_ram_req_t;

endpackage

`default_nettype wire

// File: sv/rhd_ram.sv
// ----------------------------------------------------------------------------
// rhd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/rhd_front.sv
// ----------------------------------------------------------------------------
// rhd_front
// Geometry registers, raster position, horizontal pairing and row buffer access.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rhd_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [rhd_pkg::DimBits-1:0]    cfg_wdata_i,
  input  wire logic                           accept_i,
  input  wire rhd_pkg::pixel_in_t             pixel_i,
  output rhd_pkg::rhd_item_t                  item_o,
  output rhd_pkg::rhd_ram_req_t               ram_req_o
);

  import rhd_pkg::*;

  localparam logic [DimBits-1:0] MaxWDim = DimBits'(MaxWidth);
  localparam logic [DimBits-1:0] MaxHDim = DimBits'(MaxHeight);
  localparam logic [DimBits-1:0] OneDim  = DimBits'(1);

  logic [DimBits-1:0] width_q, width_d, height_q, height_d;
  logic [PosBits-1:0] col_q, col_d, row_q, row_d;
  half_vec_t          left_q, left_d;

  logic [DimBits-1:0] w_eff, h_eff, wlim, hlim, col_ext, row_ext;
  logic               pair_x, pair_y, in_range, have_h, last_col, last_row;
  logic [1:0]         shift;
  chan_vec_t          chan, shifted, hsum;

  always_comb begin
    if (width_q == '0) begin
      w_eff = OneDim;
    end else if (width_q > MaxWDim) begin
      w_eff = MaxWDim;
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = OneDim;
    end else if (height_q > MaxHDim) begin
      h_eff = MaxHDim;
    end else begin
      h_eff = height_q;
    end
  end

  assign pair_x  = w_eff > OneDim;
  assign pair_y  = h_eff > OneDim;
  assign shift   = {1'b0, pair_x} + {1'b0, pair_y};
  assign wlim    = pair_x ? {w_eff[DimBits-1:1], 1'b0} : w_eff;
  assign hlim    = pair_y ? {h_eff[DimBits-1:1], 1'b0} : h_eff;
  assign col_ext = DimBits'(col_q);
  assign row_ext = DimBits'(row_q);

  assign in_range = (col_ext < wlim) && (row_ext < hlim);
  assign have_h   = !pair_x || col_q[0];
  assign last_col = col_ext == (w_eff - OneDim);
  assign last_row = row_ext == (h_eff - OneDim);

  assign chan = {pixel_i.in_alpha, pixel_i.in_blue, pixel_i.in_green, pixel_i.in_red};

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      shifted[c] = chan[c] >> shift;
      hsum[c]    = pair_x ? (ChanBits'(left_q[c]) + shifted[c]) : shifted[c];
      left_d[c]  = left_q[c];
    end
    if (accept_i && in_range && pair_x && !col_q[0]) begin
      for (int c = 0; c < NumChan; c++) begin
        left_d[c] = shifted[c][HalfBits-1:0];
      end
    end
  end

  always_comb begin
    item_o.emit      = in_range && have_h && (!pair_y || row_q[0]);
    item_o.add_upper = pair_y;
    item_o.frame_end = (col_ext == (wlim - OneDim)) && (row_ext == (hlim - OneDim));
    item_o.hsum      = hsum;

    ram_req_o.we   = accept_i && in_range && have_h && pair_y && !row_q[0];
    ram_req_o.re   = accept_i && in_range && have_h && pair_y && row_q[0];
    ram_req_o.addr = pair_x ? col_q[SlotBits:1] : col_q[SlotBits-1:0];
    for (int c = 0; c < NumChan; c++) begin
      ram_req_o.wdata[c] = hsum[c][HalfBits-1:0];
    end
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgImageWidth: begin
          width_d = cfg_wdata_i;
          col_d   = '0;
          row_d   = '0;
        end
        CfgImageHeight: begin
          height_d = cfg_wdata_i;
          col_d    = '0;
          row_d    = '0;
        end
        default: ;
      endcase
    end else if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + PosBits'(1);
      end else begin
        col_d = col_q + PosBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= OneDim;
      height_q <= OneDim;
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      left_q   <= left_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/rhd_back.sv
// ----------------------------------------------------------------------------
// rhd_back
// Vertical merge with the buffered upper row and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire rhd_pkg::rhd_item_t  item_i,
  input  wire rhd_pkg::half_vec_t  upper_i,
  input  wire logic                out_stall_i,
  output logic                     out_valid_o,
  output rhd_pkg::pixel_out_t      out_pixel_o,
  output logic                     in_stall_o
);

  import rhd_pkg::*;

  logic       s1_valid_q, s1_valid_d, out_valid_q, out_valid_d, s1_go;
  rhd_item_t  s1_q;
  pixel_out_t out_q;
  chan_vec_t  merged;

  // The merge stage moves on whenever the output register is empty or its
  // beat is being taken.
  assign s1_go      = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_go;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      merged[c] = s1_q.add_upper ? (s1_q.hsum[c] + ChanBits'(upper_i[c])) : s1_q.hsum[c];
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_go) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (accept_i) begin
      s1_valid_d = item_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && item_i.emit) begin
      s1_q <= item_i;
    end
    if (s1_valid_q && s1_go) begin
      out_q.out_red   <= merged[0];
      out_q.out_green <= merged[1];
      out_q.out_blue  <= merged[2];
      out_q.out_alpha <= merged[3];
      out_q.frame_end <= s1_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_q;

endmodule

`default_nettype wire

// File: sv/rgba_half_downsample_core.sv
// ----------------------------------------------------------------------------
// rgba_half_downsample_core
// One mipmap reduction step on a raster stream of RGBA8 pixels.
// ----------------------------------------------------------------------------
// Source pixels enter on the in channel in raster order, one beat per pixel,
// and reduced pixels leave on the out channel; frame_end flags the last one.
// Both channels use valid and stall. Width and height are written on the
// configuration channel (index 0 width, index 1 height), which is always
// ready; a write to either restarts the frame at the top left pixel. Write them only
// while no beat is in flight.
// A pixel is taken every cycle unless the input stalls. A 2x2 box needs one
// row buffer of width/2 entries: the upper row's pair sums are written there
// and read back when the lower row arrives, registered at the edge that loads
// the merge stage. A result passes the merge stage and the output register
// after the beat that completes its box; other pixels produce no beat.
// When the receiver stalls, the output register and the merge stage hold,
// and the input stalls only once both are full.
// Reset sets width and height to 1 and the position to zero; the row buffer
// is not cleared, since every entry is written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_half_downsample_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rhd_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [rhd_pkg::DimBits-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire rhd_pkg::pixel_in_t             in_pixel_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output rhd_pkg::pixel_out_t                 out_pixel_o
);

  import rhd_pkg::*;

  logic         accept;
  rhd_item_t    item;
  rhd_ram_req_t ram_req;
  logic [RamBits-1:0] ram_rdata;
  half_vec_t    upper;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !in_stall_o;
  assign upper       = ram_rdata;

  rhd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .pixel_i     (in_pixel_i),
    .item_o      (item),
    .ram_req_o   (ram_req)
  );

  rhd_ram #(
    .Width (RamBits),
    .Depth (RowSlots)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.addr),
    .rdata_o (ram_rdata)
  );

  rhd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .upper_i     (upper),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_pixel_o (out_pixel_o),
    .in_stall_o  (in_stall_o)
  );

endmodule

`default_nettype wire

// File: sv/rhd_checker.sv
// ----------------------------------------------------------------------------
// rhd_checker
// Port level assertions for the RGBA half downsample block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rhd_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire rhd_pkg::pixel_out_t out_pixel_o
);

  logic out_held, in_beat;

  assign out_held = out_valid_o && out_stall_i;
  assign in_beat  = in_valid_i && !in_stall_o;

  // A stalled output beat stays until it is taken.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o, "out beat dropped under stall")

  // Its payload does not move meanwhile.
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_held, $stable(out_pixel_o), "out payload moved")

  // The input only stalls when the receiver does.
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, !out_stall_i, !in_stall_o, "input stalled alone")

  // A fresh output beat traces back to an accepted input beat through the merge stage.
  `ASSERT_IMPLY(a_out_src, clk_i, rst_ni, $rose(out_valid_o), $past(in_beat, 2), "lone out beat")

endmodule

bind rgba_half_downsample_core rhd_checker u_rhd_checker (.*);

`default_nettype wire
